// ===== design/hcs_pkg.sv =====
// Package for the HSV colour segmentation and closing block.
// Holds sizes, register indexes, the slot type and stage control. No dependencies.
package hcs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_PASSES = 4;
	localparam int STAGES     = 2 * MAX_PASSES;
	localparam int HUE_CIRCLE = 360;

	localparam int FW_W   = 11;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	// tags in one window differ by at most 2*MAX_WIDTH+2, so this many bits tell them apart
	localparam int TAG_W  = $clog2(2 * MAX_WIDTH + 3);
	localparam int LINE_DEPTH = MAX_WIDTH - 2;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
	localparam int PASS_W     = $clog2(MAX_PASSES + 1);

	localparam logic [2:0] REG_HUE_LO = 3'd0;
	localparam logic [2:0] REG_HUE_HI = 3'd1;
	localparam logic [2:0] REG_SAT_LO = 3'd2;
	localparam logic [2:0] REG_SAT_HI = 3'd3;
	localparam logic [2:0] REG_VAL_LO = 3'd4;
	localparam logic [2:0] REG_VAL_HI = 3'd5;
	localparam logic [2:0] REG_PASSES = 3'd6;
	localparam logic [2:0] REG_WIDTH  = 3'd7;

	typedef struct packed {
		logic             valid;
		logic             mbit;
		logic             row_end;
		logic             frame_end;
		logic [COL_W-1:0] col;
		logic [TAG_W-1:0] tag;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic               push;
		logic               clear;
		logic [LINE_AW-1:0] ptr_last;
	} stage_ctl_t;

endpackage

// ===== design/hcs_pix_if.sv =====
// Pixel input channel: valid/ready handshake with the pixel fields.
// Stand-alone interface, no dependencies.
interface hcs_pix_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] pixel_hue;
	logic [7:0] pixel_sat;
	logic [7:0] pixel_val;
	logic       row_end;
	logic       frame_end;

	modport source (output valid, kind, pixel_hue, pixel_sat, pixel_val, row_end, frame_end,
		input ready);
	modport sink (input valid, kind, pixel_hue, pixel_sat, pixel_val, row_end, frame_end,
		output ready);
endinterface

// ===== design/hcs_mask_if.sv =====
// Mask result channel: valid/ready handshake with the closed mask fields.
// Stand-alone interface, no dependencies.
interface hcs_mask_if;
	logic valid;
	logic ready;
	logic mask;
	logic mask_row_end;
	logic mask_frame_end;

	modport source (output valid, mask, mask_row_end, mask_frame_end, input ready);
	modport sink (input valid, mask, mask_row_end, mask_frame_end, output ready);
endinterface

// ===== design/hsv_color_segment_close.sv =====
// HSV colour segmentation with morphological closing. Each accepted item is either a
// pixel (hue in two-degree units, saturation, value) or a flush that carries no pixel.
// A pixel is marked when twice its hue lies in the wrap-around window hue_lower..hue_upper
// (mod 360) and saturation and value lie within their inclusive limits; the mask then runs
// through close_passes (at most MAX_PASSES) rounds of 3x3 dilate and 3x3 erode, neighbours
// outside the frame ignored. Every 3x3 stage delays the stream by frame_width+1 items, so
// send twice that many flush items per round after a frame to drain it; an item that
// pushes an empty slot out of the chain gives no result. One item is taken every clock
// cycle while the output is not stalled, set by the single read-modify-write of each
// stage's line RAM per item. Writing close_passes or frame_width empties the chain and
// restarts the column count, and must be done while idle.
module hsv_color_segment_close (
	input  logic             clk,
	input  logic             arst_n,
	hcs_pix_if.sink          pixels,
	hcs_mask_if.source       masks,
	input  logic             wr_en,
	input  logic [2:0]       wr_index,
	input  logic [hcs_pkg::FW_W-1:0] wr_data
);
	// configuration
	logic [8:0]               hue_lo_q, hue_hi_q;
	logic [7:0]               sat_lo_q, sat_hi_q, val_lo_q, val_hi_q;
	logic [2:0]               passes_q;
	logic [hcs_pkg::FW_W-1:0] width_q;
	logic                     clr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_lo_q <= 9'd0;   hue_hi_q <= 9'd360;
			sat_lo_q <= 8'd0;   sat_hi_q <= 8'd255;
			val_lo_q <= 8'd0;   val_hi_q <= 8'd255;
			passes_q <= 3'd0;   width_q  <= hcs_pkg::FW_W'(640);
		end else if (wr_en) begin
			case (wr_index)
				hcs_pkg::REG_HUE_LO: hue_lo_q <= wr_data[8:0];
				hcs_pkg::REG_HUE_HI: hue_hi_q <= wr_data[8:0];
				hcs_pkg::REG_SAT_LO: sat_lo_q <= wr_data[7:0];
				hcs_pkg::REG_SAT_HI: sat_hi_q <= wr_data[7:0];
				hcs_pkg::REG_VAL_LO: val_lo_q <= wr_data[7:0];
				hcs_pkg::REG_VAL_HI: val_hi_q <= wr_data[7:0];
				hcs_pkg::REG_PASSES: passes_q <= wr_data[2:0];
				hcs_pkg::REG_WIDTH:  width_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// a write to passes or width empties the chain
	assign clr = wr_en && (wr_index == hcs_pkg::REG_PASSES || wr_index == hcs_pkg::REG_WIDTH);

	// clamp width to 3..MAX_WIDTH and passes to MAX_PASSES
	logic [hcs_pkg::FW_W-1:0]    eff_w;
	logic [hcs_pkg::COL_W-1:0]   col_last;
	logic [hcs_pkg::LINE_AW-1:0] ptr_last;
	logic [hcs_pkg::PASS_W-1:0]  eff_p;

	always_comb begin
		if (width_q < hcs_pkg::FW_W'(3))
			eff_w = hcs_pkg::FW_W'(3);
		else if (width_q > hcs_pkg::FW_W'(hcs_pkg::MAX_WIDTH))
			eff_w = hcs_pkg::FW_W'(hcs_pkg::MAX_WIDTH);
		else
			eff_w = width_q;
		if (passes_q > 3'(hcs_pkg::MAX_PASSES))
			eff_p = hcs_pkg::PASS_W'(hcs_pkg::MAX_PASSES);
		else
			eff_p = hcs_pkg::PASS_W'(passes_q);
	end
	assign col_last = hcs_pkg::COL_W'(eff_w - 1'b1);
	assign ptr_last = hcs_pkg::LINE_AW'(eff_w - hcs_pkg::FW_W'(3));

	// hue window, everything reduced below 360 first
	logic [8:0]        h2, h2r, lor, hir;
	logic signed [9:0] da, db;
	logic [9:0]        a, b;
	logic              hit;

	always_comb begin
		h2  = {pixels.pixel_hue, 1'b0};
		h2r = (h2 >= 9'(hcs_pkg::HUE_CIRCLE)) ? h2 - 9'(hcs_pkg::HUE_CIRCLE) : h2;
		lor = (hue_lo_q >= 9'(hcs_pkg::HUE_CIRCLE)) ?
			hue_lo_q - 9'(hcs_pkg::HUE_CIRCLE) : hue_lo_q;
		hir = (hue_hi_q >= 9'(hcs_pkg::HUE_CIRCLE)) ?
			hue_hi_q - 9'(hcs_pkg::HUE_CIRCLE) : hue_hi_q;
		da = $signed({1'b0, h2r}) - $signed({1'b0, lor});
		db = $signed({1'b0, hir}) - $signed({1'b0, lor});
		a  = (da < 0) ? 10'(da + 10'sd360) : 10'(da);
		b  = (db < 0) ? 10'(db + 10'sd360) : 10'(db);
		hit = (a <= b) && pixels.pixel_sat >= sat_lo_q && pixels.pixel_sat <= sat_hi_q &&
			pixels.pixel_val >= val_lo_q && pixels.pixel_val <= val_hi_q;
	end

	// handshake: the chain advances whenever the output register is free or being taken
	logic out_v_q, en, accept;
	assign en     = !out_v_q || masks.ready;
	assign pixels.ready = en;
	assign accept = pixels.valid && en;

	// column and frame tag of the next pixel
	logic [hcs_pkg::COL_W-1:0] col_q;
	logic [hcs_pkg::TAG_W-1:0] tag_q;
	hcs_pkg::slot_t            slot_in, x0_q;
	logic                      pv0_q;

	always_comb begin
		slot_in = '0;
		if (!pixels.kind) begin
			slot_in.valid     = 1'b1;
			slot_in.mbit      = hit;
			slot_in.col       = col_q;
			slot_in.tag       = tag_q;
			slot_in.frame_end = pixels.frame_end;
			slot_in.row_end   = (col_q == col_last) || pixels.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			tag_q <= '0;
		end else if (clr) begin
			col_q <= '0;
		end else if (accept && !pixels.kind) begin
			if (pixels.frame_end) begin
				col_q <= '0;
				tag_q <= tag_q + 1'b1;
			end else begin
				col_q <= (col_q == col_last) ? '0 : col_q + 1'b1;
			end
		end
	end

	// input register: holds the thresholded slot for the first stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv0_q <= 1'b0;
			x0_q  <= '0;
		end else if (clr) begin
			pv0_q <= 1'b0;
		end else if (en) begin
			pv0_q <= accept;
			x0_q  <= slot_in;
		end
	end

	// stage chain: each stage pushes when the one before has a fresh slot
	hcs_pkg::slot_t             stg_out [hcs_pkg::STAGES];
	hcs_pkg::stage_ctl_t        ctl     [hcs_pkg::STAGES];
	logic [hcs_pkg::STAGES-1:0] fr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fr_q <= '0;
		else if (clr)
			fr_q <= '0;
		else if (en)
			fr_q <= {fr_q[hcs_pkg::STAGES-2:0], pv0_q};
	end

	for (genvar s = 0; s < hcs_pkg::STAGES; s++) begin : g_stage
		if (s == 0) begin : g_first
			assign ctl[s].push = en && pv0_q && !clr;
		end else begin : g_next
			assign ctl[s].push = en && fr_q[s-1] && !clr;
		end
		assign ctl[s].clear    = clr;
		assign ctl[s].ptr_last = ptr_last;

		hcs_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[s]),
			.dilate (s % 2 == 0),
			.x      ((s == 0) ? x0_q : stg_out[(s == 0) ? 0 : s-1]),
			.y      (stg_out[s])
		);
	end

	// pick the end of the chain that the pass count selects
	hcs_pkg::slot_t sel;
	logic           sel_v;

	always_comb begin
		sel   = x0_q;
		sel_v = pv0_q;
		for (int k = 1; k <= hcs_pkg::MAX_PASSES; k++) begin
			if (eff_p == hcs_pkg::PASS_W'(k)) begin
				sel   = stg_out[2*k-1];
				sel_v = fr_q[2*k-1];
			end
		end
	end

	// output register
	logic out_mask_q, out_re_q, out_fe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (clr) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= sel_v && sel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_mask_q <= sel.mbit;
			out_re_q   <= sel.row_end;
			out_fe_q   <= sel.frame_end;
		end
	end

	assign masks.valid          = out_v_q;
	assign masks.mask           = out_mask_q;
	assign masks.mask_row_end   = out_re_q;
	assign masks.mask_frame_end = out_fe_q;

	// the column never passes the last column of the current width
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= col_last)
		else $error("column counter beyond row width");

	// a result that ends its frame also ends its row
	a_fe_re: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_fe_q |-> out_re_q)
		else $error("frame end without row end");

	// emptying the chain drops any pending result
	a_clr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> !out_v_q && fr_q == '0 && !pv0_q)
		else $error("chain not empty after clear");

	// a stalled output holds its slot and the chain freezes
	a_stall_fr: assert property (@(posedge clk) disable iff (!arst_n)
		!en && !clr |=> $stable(fr_q) && $stable(pv0_q))
		else $error("chain moved while output stalled");
endmodule

// ===== design/hcs_ram.sv =====
// Generic single-clock RAM, one write and one read port, registered read (read-first).
// No dependencies.
module hcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem[raddr];
		if (we)
			mem[waddr] <= wdata;
	end

	assign rdata = rdata_q;
endmodule

// ===== design/hcs_stage.sv =====
// One 3x3 dilate or erode stage: window flops plus two line delays in one RAM.
// Depends on hcs_pkg and hcs_ram.
module hcs_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  hcs_pkg::stage_ctl_t ctl,
	input  logic               dilate,
	input  hcs_pkg::slot_t     x,
	output hcs_pkg::slot_t     y
);
	hcs_pkg::slot_t r0_q, r1_q, r2_q, m1_q, m2_q, t1_q, t2_q;
	hcs_pkg::slot_t m0, t0, c;
	logic [hcs_pkg::LINE_AW-1:0]  ptr_q;
	logic [hcs_pkg::FILL_W-1:0]   fill_q, fill_full;
	logic                         ok_q;
	logic [2*hcs_pkg::SLOT_W-1:0] rd, wd;
	logic [7:0]                   hit, nbit;
	logic                         acc;

	assign fill_full = hcs_pkg::FILL_W'(ctl.ptr_last) + 1'b1;
	assign wd = {r1_q, m1_q};

	hcs_ram #(.WIDTH(2 * hcs_pkg::SLOT_W), .DEPTH(hcs_pkg::LINE_DEPTH)) u_line (
		.clk   (clk),
		.we    (ctl.push),
		.waddr (ptr_q),
		.wdata (wd),
		.re    (ctl.push),
		.raddr (ptr_q),
		.rdata (rd)
	);

	// entries older than the last clear read as empty
	always_comb begin
		m0 = rd[2*hcs_pkg::SLOT_W-1:hcs_pkg::SLOT_W];
		t0 = rd[hcs_pkg::SLOT_W-1:0];
		m0.valid = m0.valid & ok_q;
		t0.valid = t0.valid & ok_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0; fill_q <= '0; ok_q <= 1'b0;
			r0_q <= '0; r1_q <= '0; r2_q <= '0;
			m1_q <= '0; m2_q <= '0; t1_q <= '0; t2_q <= '0;
		end else if (ctl.clear) begin
			ptr_q <= '0; fill_q <= '0; ok_q <= 1'b0;
			r0_q <= '0; r1_q <= '0; r2_q <= '0;
			m1_q <= '0; m2_q <= '0; t1_q <= '0; t2_q <= '0;
		end else if (ctl.push) begin
			ptr_q  <= (ptr_q == ctl.ptr_last) ? '0 : ptr_q + 1'b1;
			fill_q <= (fill_q == fill_full) ? fill_q : fill_q + 1'b1;
			ok_q   <= (fill_q == fill_full);
			r0_q <= x;    r1_q <= r0_q; r2_q <= r1_q;
			m1_q <= m0;   m2_q <= m1_q;
			t1_q <= t0;   t2_q <= t1_q;
		end
	end

	// centre is m1; neighbours to the right, same column and left
	// (columns compared one bit wider so the last column has no right neighbour)
	assign c = m1_q;
	always_comb begin
		hit[0] = r0_q.valid && r0_q.tag == c.tag && {1'b0, r0_q.col} == {1'b0, c.col} + 1'b1;
		hit[1] = m0.valid   && m0.tag   == c.tag && {1'b0, m0.col}   == {1'b0, c.col} + 1'b1;
		hit[2] = t0.valid   && t0.tag   == c.tag && {1'b0, t0.col}   == {1'b0, c.col} + 1'b1;
		hit[3] = r1_q.valid && r1_q.tag == c.tag && r1_q.col == c.col;
		hit[4] = t1_q.valid && t1_q.tag == c.tag && t1_q.col == c.col;
		hit[5] = r2_q.valid && r2_q.tag == c.tag && {1'b0, r2_q.col} + 1'b1 == {1'b0, c.col};
		hit[6] = m2_q.valid && m2_q.tag == c.tag && {1'b0, m2_q.col} + 1'b1 == {1'b0, c.col};
		hit[7] = t2_q.valid && t2_q.tag == c.tag && {1'b0, t2_q.col} + 1'b1 == {1'b0, c.col};
		nbit = {t2_q.mbit, m2_q.mbit, r2_q.mbit, t1_q.mbit, r1_q.mbit,
			t0.mbit, m0.mbit, r0_q.mbit};
		if (dilate)
			acc = c.mbit | (|(hit & nbit));
		else
			acc = c.mbit & (&(~hit | nbit));
		y = c;
		if (c.valid)
			y.mbit = acc;
	end
endmodule

// ===== tb/tb_hsv_color_segment_close.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for hsv_color_segment_close: HSV threshold followed by 3x3 closing.
// Depends on hsv_color_segment_close, hcs_pkg, hcs_pix_if and hcs_mask_if; runs standalone, no files read.
module tb_hsv_color_segment_close;

	localparam int RING_LEN   = 2 * hcs_pkg::MAX_WIDTH + 3;
	localparam int IDLE_LIMIT = 5000;  // cycles without any accepted item
	localparam int SETTLE     = 2 * hcs_pkg::MAX_PASSES + 24;
	localparam int LONG_HOLD  = 400;

	typedef struct {
		bit valid;
		bit mbit;
		bit row_end;
		bit frame_end;
		int col;
		int tag;
	} px_slot_t;

	typedef struct {
		bit mask;
		bit row_end;
		bit frame_end;
	} mask_item_t;

	typedef struct {
		bit       kind;
		bit [7:0] hue;
		bit [7:0] sat;
		bit [7:0] val;
		bit       row_end;
		bit       frame_end;
		bit       typed;
		bit       m;
		bit       mre;
		bit       mfe;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_index;
	logic [hcs_pkg::FW_W-1:0] wr_data;

	hcs_pix_if  pixels ();
	hcs_mask_if masks ();

	hsv_color_segment_close i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pixels),
		.masks    (masks),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Mirror of the block's registers and line stores
	int hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi, passes_reg, width_reg;
	px_slot_t line_ring [hcs_pkg::STAGES][RING_LEN];
	int ring_pos [hcs_pkg::STAGES];
	int next_col;
	int frame_no;

	mask_item_t pending_masks [$];
	int fails;
	int pix_sent;
	int idle_cycles;
	bit tx_calm, rx_calm;
	bit rx_hold_req;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	task automatic report(input string what, input int exp_v, input int got_v);
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
		fails++;
	endtask

	function automatic int width_eff();
		if (width_reg < 3) return 3;
		if (width_reg > hcs_pkg::MAX_WIDTH) return hcs_pkg::MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int passes_eff();
		return (passes_reg > hcs_pkg::MAX_PASSES) ? hcs_pkg::MAX_PASSES : passes_reg;
	endfunction

	function automatic void empty_rings();
		for (int s = 0; s < hcs_pkg::STAGES; s++) begin
			ring_pos[s] = 0;
			for (int i = 0; i < RING_LEN; i++)
				line_ring[s][i] = '{default: 0};
		end
		next_col = 0;
	endfunction

	function automatic bit hsv_marked(input int h, input int s, input int v);
		int a, b;
		a = (2 * h + 2 * hcs_pkg::HUE_CIRCLE - hue_lo) % hcs_pkg::HUE_CIRCLE;
		b = (hue_hi + 2 * hcs_pkg::HUE_CIRCLE - hue_lo) % hcs_pkg::HUE_CIRCLE;
		return a <= b && s >= sat_lo && s <= sat_hi && v >= val_lo && v <= val_hi;
	endfunction

	// One 3x3 stage: even stages dilate, odd stages erode; neighbours count only
	// when they belong to the same frame and the expected column.
	function automatic px_slot_t morph_stage(input int s, input px_slot_t t, input int w);
		int hd, k;
		px_slot_t c, n;
		bit acc;
		hd = (ring_pos[s] + 1) % RING_LEN;
		ring_pos[s] = hd;
		line_ring[s][hd] = t;
		c = line_ring[s][(hd + RING_LEN - (w + 1)) % RING_LEN];
		if (!c.valid) return c;
		acc = c.mbit;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				if (dr == 0 && dc == 0) continue;
				k = w + 1 - (dr * w + dc);
				n = line_ring[s][(hd + RING_LEN - k) % RING_LEN];
				if (n.valid && n.tag == c.tag && n.col == c.col + dc)
					acc = (s % 2 == 0) ? (acc | n.mbit) : (acc & n.mbit);
			end
		end
		c.mbit = acc;
		return c;
	endfunction

	function automatic bit closed_mask_next(input bit k, input int h, input int s, input int v,
			input bit fe, output mask_item_t res);
		px_slot_t t;
		int w;
		w = width_eff();
		t = '{default: 0};
		if (!k) begin
			t.valid = 1;
			t.mbit = hsv_marked(h, s, v);
			t.col = next_col;
			t.tag = frame_no;
			t.frame_end = fe;
			t.row_end = (next_col == w - 1) || fe;
			if (fe) begin
				next_col = 0;
				frame_no++;
			end else begin
				next_col = (next_col + 1 >= w) ? 0 : next_col + 1;
			end
		end
		for (int st = 0; st < 2 * passes_eff(); st++)
			t = morph_stage(st, t, w);
		res = '{t.mbit, t.row_end, t.frame_end};
		return t.valid;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Write one register, mirror it, and drop pending pixels where the block does
	task automatic write_reg(input logic [2:0] idx, input int value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value[hcs_pkg::FW_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			hcs_pkg::REG_HUE_LO: hue_lo = value & 'h1FF;
			hcs_pkg::REG_HUE_HI: hue_hi = value & 'h1FF;
			hcs_pkg::REG_SAT_LO: sat_lo = value & 'hFF;
			hcs_pkg::REG_SAT_HI: sat_hi = value & 'hFF;
			hcs_pkg::REG_VAL_LO: val_lo = value & 'hFF;
			hcs_pkg::REG_VAL_HI: val_hi = value & 'hFF;
			hcs_pkg::REG_PASSES: begin
				passes_reg = value & 'h7;
				empty_rings();
			end
			hcs_pkg::REG_WIDTH: begin
				width_reg = value & 'h7FF;
				empty_rings();
			end
			default: ;
		endcase
	endtask

	// Offer one item, hold it until taken, then predict its result
	task automatic send_item(input bit k, input bit [7:0] h, input bit [7:0] s,
			input bit [7:0] v, input bit re, input bit fe, input bit typed,
			input mask_item_t typed_res);
		int gap;
		bit has;
		mask_item_t res;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			pixels.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixels.valid <= 1'b1;
		pixels.kind <= k;
		pixels.pixel_hue <= h;
		pixels.pixel_sat <= s;
		pixels.pixel_val <= v;
		pixels.row_end <= re;
		pixels.frame_end <= fe;
		do @(posedge clk); while (!pixels.ready);
		has = closed_mask_next(k, h, s, v, fe, res);
		if (typed) begin
			if (!has) report("typed row gave no result, row", 1, 0);
			res = typed_res;
		end
		if (has) pending_masks.push_back(res);
		if (!k) pix_sent++;
	endtask

	task automatic send_random(input bit k, input bit fe);
		send_item(k, 8'($urandom_range(179)), 8'($urandom), 8'($urandom), 1'($urandom),
			fe, 1'b0, '{0, 0, 0});
	endtask

	// Stop offering and let every result and any trailing flush clear the block
	task automatic drain_idle();
		pixels.valid <= 1'b0;
		while (pending_masks.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One setting: program every register, stream frames, then flush the tail out
	task automatic run_phase(input int hl, input int hu, input int sl, input int su,
			input int vl, input int vu, input int cp, input int fw, input int budget);
		int w, n, rows, sent;
		write_reg(hcs_pkg::REG_HUE_LO, hl);
		write_reg(hcs_pkg::REG_HUE_HI, hu);
		write_reg(hcs_pkg::REG_SAT_LO, sl);
		write_reg(hcs_pkg::REG_SAT_HI, su);
		write_reg(hcs_pkg::REG_VAL_LO, vl);
		write_reg(hcs_pkg::REG_VAL_HI, vu);
		write_reg(hcs_pkg::REG_PASSES, cp);
		write_reg(hcs_pkg::REG_WIDTH, fw);
		w = width_eff();
		tx_calm = ($urandom_range(3) == 0);
		rx_calm = ($urandom_range(3) == 0);
		sent = 0;
		while (sent < budget) begin
			rows = (w > 64) ? 1 : $urandom_range(1, 5);
			n = rows * w;
			// now and then end the frame part-way through its last row
			if ($urandom_range(4) == 0) n -= $urandom_range(1, w - 1);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(40) == 0) send_random(1'b1, 1'($urandom));
				send_random(1'b0, i == n - 1);
			end
			sent += n;
		end
		for (int i = 0; i < 2 * passes_eff() * (w + 1); i++)
			send_random(1'b1, 1'($urandom));
		tx_calm = 0;
		rx_calm = 0;
		drain_idle();
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold, gap;
		hold = 0;
		gap = 0;
		masks.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 0;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				masks.ready <= 1'b0;
				hold--;
			end else if (gap > 0) begin
				masks.ready <= 1'b0;
				gap--;
			end else begin
				masks.ready <= 1'b1;
				if (!rx_calm && $urandom_range(7) == 0) gap = pick_gap();
			end
		end
	end

	// Compare every accepted mask item with the oldest prediction
	always @(posedge clk) begin
		mask_item_t e;
		if (arst_n && masks.valid && masks.ready) begin
			if (pending_masks.size() == 0) begin
				report("mask item with none expected, mask", -1, masks.mask);
			end else begin
				e = pending_masks.pop_front();
				if (masks.mask !== e.mask) report("mask", e.mask, masks.mask);
				if (masks.mask_row_end !== e.row_end)
					report("mask_row_end", e.row_end, masks.mask_row_end);
				if (masks.mask_frame_end !== e.frame_end)
					report("mask_frame_end", e.frame_end, masks.mask_frame_end);
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((pixels.valid && pixels.ready) || (masks.valid && masks.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		dir_row_t dir_tab [9];
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		pixels.valid = 1'b0;
		pixels.kind = 1'b0;
		pixels.pixel_hue = '0;
		pixels.pixel_sat = '0;
		pixels.pixel_val = '0;
		pixels.row_end = 1'b0;
		pixels.frame_end = 1'b0;
		fails = 0;
		pix_sent = 0;
		tx_calm = 0;
		rx_calm = 0;
		rx_hold_req = 0;
		hue_lo = 0;
		hue_hi = 360;
		sat_lo = 0;
		sat_hi = 255;
		val_lo = 0;
		val_hi = 255;
		passes_reg = 0;
		width_reg = 640;
		frame_no = 0;
		empty_rings();

		// After reset the hue window has zero width, so only hues 0 and 180 mark;
		// no closing, so each pixel comes straight out.
		dir_tab = '{
			'{0, 8'd0,   8'd0,   8'd0,   0, 0, 1, 1, 0, 0},
			'{0, 8'd179, 8'd255, 8'd255, 1, 0, 1, 0, 0, 0},
			'{0, 8'd90,  8'd128, 8'd128, 0, 0, 1, 0, 0, 0},
			'{0, 8'd0,   8'd255, 8'd255, 0, 0, 1, 1, 0, 0},
			'{1, 8'd255, 8'd255, 8'd255, 1, 1, 0, 0, 0, 0},
			'{0, 8'd1,   8'd0,   8'd255, 0, 0, 1, 0, 0, 0},
			'{0, 8'd0,   8'd255, 8'd0,   0, 1, 1, 1, 1, 1},
			'{0, 8'd127, 8'd85,  8'd170, 1, 0, 1, 0, 0, 0},
			'{1, 8'd0,   8'd0,   8'd0,   0, 0, 0, 0, 0, 0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_item(dir_tab[i].kind, dir_tab[i].hue, dir_tab[i].sat, dir_tab[i].val,
				dir_tab[i].row_end, dir_tab[i].frame_end, dir_tab[i].typed,
				'{dir_tab[i].m, dir_tab[i].mre, dir_tab[i].mfe});
		drain_idle();

		// wrapping hue window, one closing round, narrowest row
		run_phase(300, 60, 0, 255, 0, 255, 1, 3, 60);
		// hue bounds past the circle, passes above the maximum, width below the minimum;
		// hold the receiver off so the block fills and stalls its input
		rx_hold_req = 1;
		run_phase(511, 0, 40, 200, 30, 255, 7, 0, 90);
		// widest rows, clamped from the top of the register
		run_phase(0, 180, 0, 255, 0, 255, 0, 2047, 1);
		run_phase(100, 250, 255, 255, 0, 0, 4, 20, 1);
		run_phase(0, 360, 0, 0, 255, 255, 0, 7, 40);

		while (pix_sent < 1300)
			run_phase($urandom_range(360), $urandom_range(360), $urandom_range(80),
				$urandom_range(120, 255), $urandom_range(80), $urandom_range(120, 255),
				$urandom_range(7), $urandom_range(16), $urandom_range(30, 120));

		drain_idle();
		if (fails == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== hsv_color_segment_close.f =====
design/hcs_pkg.sv
design/hcs_pix_if.sv
design/hcs_mask_if.sv
design/hcs_ram.sv
design/hcs_stage.sv
design/hsv_color_segment_close.sv
tb/tb_hsv_color_segment_close.sv
